>>> rtl/steg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package steg_pkg;

    // Table and index sizes
    localparam int SINE_TABLE_BITS = 10;
    localparam int INDEX_BITS      = 20;
    localparam int SINE_QBITS      = SINE_TABLE_BITS - 2;
    localparam int SINE_QUARTER    = 1 << SINE_QBITS;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVEFORM,
        CFG_START_INC,
        CFG_SWEEP_STEP,
        CFG_PROGRESS_STEP,
        CFG_ATTACK_LENGTH,
        CFG_ATTACK_STEP,
        CFG_DECAY_FACTOR,
        CFG_VOLUME
    } cfg_index_t;

    // Waveform codes; the remaining codes give silence
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SAW      = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    // Noise generator
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Progress accumulator, Q.24 with one guard bit
    localparam int PROG_W = 25;
    localparam logic [PROG_W-1:0] PROG_ONE = 25'h100_0000;

    // Attack compare width
    localparam int ATT_CMP_W = (INDEX_BITS > 20) ? INDEX_BITS : 20;

    // Digit-serial multiplier geometry
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_B_MIN   = 17;
    localparam int MUL_DIGITS  = (MUL_B_MIN + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
    localparam int MUL_BW      = MUL_DIGITS * MUL_DIGIT_W;
    localparam int MUL_AW      = (INDEX_BITS > MUL_B_MIN) ? INDEX_BITS : MUL_B_MIN;
    localparam int MUL_PW      = MUL_AW + MUL_BW;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS + 1);

    typedef struct packed {
        logic [2:0]         waveform;
        logic [30:0]        start_increment;
        logic signed [20:0] sweep_step;
        logic [24:0]        progress_step;
        logic [19:0]        attack_length;
        logic [15:0]        attack_step;
        logic [15:0]        decay_factor;
        logic [15:0]        volume;
    } steg_cfg_t;

    localparam steg_cfg_t CFG_RESET = '{
        waveform:        WAVE_SINE,
        start_increment: 31'd0,
        sweep_step:      21'sd0,
        progress_step:   25'd65536,
        attack_length:   20'd220,
        attack_step:     16'd297,
        decay_factor:    16'd65530,
        volume:          16'd32768
    };

    typedef struct packed {
        logic              load;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } steg_mul_req_t;

    typedef struct packed {
        logic              busy;
        logic [MUL_PW-1:0] product;
    } steg_mul_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_LOAD,
        ST_MUL,
        ST_UPDATE,
        ST_OUT
    } steg_state_t;

    typedef enum logic [2:0] {
        OP_ENV,
        OP_DECAY,
        OP_FADE,
        OP_ENV_FADE,
        OP_VOLUME,
        OP_TONE
    } steg_op_t;

    // Quarter-wave sine magnitudes, Q1.15
    typedef logic [14:0] sine_lut_t [SINE_QUARTER];

    function automatic sine_lut_t sine_lut_build();
        sine_lut_t   lut;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] in1;
        logic [63:0] in2;
        logic [63:0] y;
        logic [63:0] v;
        for (int i = 0; i < SINE_QUARTER; i++) begin
            x   = 64'(i) << (16 - SINE_QBITS);
            x2  = (x * x) >> 16;
            in1 = 64'd42048 - ((64'd4640 * x2) >> 16);
            in2 = 64'd102944 - ((x2 * in1) >> 16);
            y   = (x * in2) >> 16;
            v   = (y + 64'd1) >> 1;
            lut[i] = (v > 64'd32767) ? 15'h7FFF : v[14:0];
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = sine_lut_build();

endpackage

`default_nettype wire

>>> rtl/swept_tone_envelope_generator.sv
// While no tone sounds and without restart, a request goes straight to the output register;
// otherwise the phase advances, six products go one after another through one 4-bit
// digit-serial multiplier, the voice state is stepped and the result is registered. Only
// then is a new request taken; the output register lets it in while a result still waits.
// Reset (aresetn low, synchronous) restores register defaults, silences the voice and
// reseeds the noise generator.
`timescale 1ns / 1ps
`default_nettype none

module swept_tone_envelope_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [steg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [steg_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [15:0]               s_mix_in,
    input  logic                             s_restart,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_mix_out,
    output logic signed [15:0]               m_tone_sample,
    output logic                             m_active,
    output logic                             m_last
);
    import steg_pkg::*;

    steg_cfg_t     cfg;
    steg_mul_req_t mul_req;
    steg_mul_rsp_t mul_rsp;

    steg_state_t state_reg;
    steg_state_t state_next;
    steg_op_t    op_reg;
    steg_op_t    op_next;

    // Voice state
    logic [31:0]           phase_acc_reg;
    logic [31:0]           phase_acc_next;
    logic [31:0]           phase_inc_reg;
    logic [31:0]           phase_inc_next;
    logic [INDEX_BITS-1:0] sample_index_reg;
    logic [INDEX_BITS-1:0] sample_index_next;
    logic [PROG_W-1:0]     progress_reg;
    logic [PROG_W-1:0]     progress_next;
    logic [15:0]           decay_level_reg;
    logic [15:0]           decay_level_next;
    logic [15:0]           lfsr_reg;
    logic [15:0]           lfsr_next;
    logic                  sounding_reg;
    logic                  sounding_next;

    // Working values of the current request
    logic signed [15:0] mix_reg;
    logic signed [15:0] mix_next;
    logic signed [15:0] tone_reg;
    logic signed [15:0] tone_next;
    logic               active_reg;
    logic               active_next;
    logic               last_reg;
    logic               last_next;
    logic               in_attack_reg;
    logic               in_attack_next;
    logic [15:0]        env_reg;
    logic [15:0]        env_next;
    logic [15:0]        fade_reg;
    logic [15:0]        fade_next;
    logic [15:0]        gain_reg;
    logic [15:0]        gain_next;
    logic [15:0]        decay_new_reg;
    logic [15:0]        decay_new_next;

    // Output register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic signed [15:0] m_mix_out_reg;
    logic signed [15:0] m_mix_out_next;
    logic signed [15:0] m_tone_reg;
    logic signed [15:0] m_tone_next;
    logic               m_active_reg;
    logic               m_active_next;
    logic               m_last_reg;
    logic               m_last_next;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic               mul_load;
    logic               mul_done;
    logic signed [15:0] osc;
    logic [15:0]        osc_u;
    logic [15:0]        osc_mag;
    logic [16:0]        p_q16;

    steg_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    steg_digit_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    steg_osc u_osc (
        .waveform (cfg.waveform),
        .phase    (phase_acc_reg),
        .lfsr     (lfsr_reg),
        .osc      (osc)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mul_done = !mul_rsp.busy;
    assign osc_u    = unsigned'(osc);
    assign osc_mag  = osc_u[15] ? (~osc_u + 16'd1) : osc_u;
    assign p_q16    = progress_reg[PROG_W-1:8];

    // Next state and next product
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_restart || sounding_reg) ? ST_ADVANCE : ST_OUT;
                    op_next    = OP_ENV;
                end
            end
            ST_ADVANCE: state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_MUL;
            ST_MUL: begin
                if (mul_done) begin
                    unique case (op_reg)
                        OP_ENV:      op_next = OP_DECAY;
                        OP_DECAY:    op_next = OP_FADE;
                        OP_FADE:     op_next = OP_ENV_FADE;
                        OP_ENV_FADE: op_next = OP_VOLUME;
                        OP_VOLUME:   op_next = OP_TONE;
                        default:     op_next = OP_TONE;
                    endcase
                    state_next = (op_reg == OP_TONE) ? ST_UPDATE : ST_LOAD;
                end
            end
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State machine outputs
    always_comb begin
        s_ready  = 1'b0;
        mul_load = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_LOAD: mul_load = 1'b1;
            ST_OUT:  out_load = out_free;
            default: s_ready  = 1'b0;
        endcase
    end

    // Select multiplier operands for the current product
    always_comb begin
        mul_req.load = mul_load;
        unique case (op_reg)
            OP_ENV: begin
                mul_req.a = MUL_AW'(sample_index_reg);
                mul_req.b = MUL_BW'(cfg.attack_step);
            end
            OP_DECAY: begin
                mul_req.a = MUL_AW'(decay_level_reg);
                mul_req.b = MUL_BW'(cfg.decay_factor);
            end
            OP_FADE: begin
                mul_req.a = MUL_AW'(p_q16);
                mul_req.b = MUL_BW'(p_q16);
            end
            OP_ENV_FADE: begin
                mul_req.a = MUL_AW'(env_reg);
                mul_req.b = MUL_BW'(fade_reg);
            end
            OP_VOLUME: begin
                mul_req.a = MUL_AW'(gain_reg);
                mul_req.b = MUL_BW'(cfg.volume);
            end
            default: begin
                mul_req.a = MUL_AW'(osc_mag);
                mul_req.b = MUL_BW'(gain_reg);
            end
        endcase
    end

    // Voice datapath
    always_comb begin
        logic [16:0] pp_hi;
        logic [31:0] tone_prod;
        logic [33:0] inc_sum;
        logic [25:0] prog_sum;

        phase_acc_next    = phase_acc_reg;
        phase_inc_next    = phase_inc_reg;
        sample_index_next = sample_index_reg;
        progress_next     = progress_reg;
        decay_level_next  = decay_level_reg;
        lfsr_next         = lfsr_reg;
        sounding_next     = sounding_reg;
        mix_next          = mix_reg;
        tone_next         = tone_reg;
        active_next       = active_reg;
        last_next         = last_reg;
        in_attack_next    = in_attack_reg;
        env_next          = env_reg;
        fade_next         = fade_reg;
        gain_next         = gain_reg;
        decay_new_next    = decay_new_reg;
        pp_hi             = mul_rsp.product[32:16];
        tone_prod         = osc_u[15] ? (~mul_rsp.product[31:0] + 32'd1)
                                      : mul_rsp.product[31:0];
        inc_sum           = {2'b00, phase_inc_reg}
                          + {{13{cfg.sweep_step[20]}}, cfg.sweep_step};
        prog_sum          = {1'b0, progress_reg} + {1'b0, cfg.progress_step};

        // Take the request; a restart rewinds the voice before it sounds
        if (accept) begin
            mix_next    = s_mix_in;
            tone_next   = '0;
            active_next = s_restart || sounding_reg;
            last_next   = 1'b0;
            if (s_restart) begin
                phase_acc_next    = '0;
                phase_inc_next    = {1'b0, cfg.start_increment};
                sample_index_next = '0;
                progress_next     = '0;
                decay_level_next  = 16'hFFFF;
                sounding_next     = 1'b1;
            end
        end

        // Advance the phase and note whether the attack is still running
        if (state_reg == ST_ADVANCE) begin
            phase_acc_next = phase_acc_reg + phase_inc_reg;
            in_attack_next = ATT_CMP_W'(sample_index_reg) < ATT_CMP_W'(cfg.attack_length);
        end

        // Capture each finished product
        if ((state_reg == ST_MUL) && mul_done) begin
            case (op_reg)
                OP_ENV: begin
                    if (!in_attack_reg) begin
                        env_next = decay_level_reg;
                    end else if (|mul_rsp.product[MUL_PW-1:16]) begin
                        env_next = 16'hFFFF;
                    end else begin
                        env_next = mul_rsp.product[15:0];
                    end
                end
                OP_DECAY: decay_new_next = mul_rsp.product[31:16];
                OP_FADE: begin
                    fade_next = (pp_hi == '0) ? 16'hFFFF : 16'(17'h1_0000 - pp_hi);
                end
                OP_ENV_FADE: gain_next = mul_rsp.product[31:16];
                OP_VOLUME:   gain_next = mul_rsp.product[31:16];
                default:     tone_next = signed'(tone_prod[31:16]);
            endcase
        end

        // Step noise, sweep, index, progress and decay for the next sample
        if (state_reg == ST_UPDATE) begin
            lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
            if (inc_sum[33]) begin
                phase_inc_next = '0;
            end else if (inc_sum[32]) begin
                phase_inc_next = '1;
            end else begin
                phase_inc_next = inc_sum[31:0];
            end
            if (sample_index_reg != '1) begin
                sample_index_next = sample_index_reg + 1'b1;
            end
            if (|prog_sum[25:24]) begin
                last_next     = 1'b1;
                sounding_next = 1'b0;
                progress_next = PROG_ONE;
            end else begin
                progress_next = prog_sum[PROG_W-1:0];
            end
            if (!in_attack_reg) begin
                decay_level_next = decay_new_reg;
            end
        end
    end

    // Output register: add the tone to the mix with saturation
    always_comb begin
        logic [16:0] msum;

        m_valid_next   = m_valid_reg && !m_ready;
        m_mix_out_next = m_mix_out_reg;
        m_tone_next    = m_tone_reg;
        m_active_next  = m_active_reg;
        m_last_next    = m_last_reg;
        msum           = {mix_reg[15], mix_reg} + {tone_reg[15], tone_reg};
        if (out_load) begin
            m_valid_next = 1'b1;
            if (msum[16] != msum[15]) begin
                m_mix_out_next = msum[16] ? 16'sh8000 : 16'sh7FFF;
            end else begin
                m_mix_out_next = signed'(msum[15:0]);
            end
            m_tone_next   = tone_reg;
            m_active_next = active_reg;
            m_last_next   = last_reg;
        end
    end

    // Control and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_ENV;
            m_valid_reg      <= 1'b0;
            phase_acc_reg    <= '0;
            phase_inc_reg    <= '0;
            sample_index_reg <= '0;
            progress_reg     <= '0;
            decay_level_reg  <= 16'hFFFF;
            lfsr_reg         <= LFSR_SEED;
            sounding_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            m_valid_reg      <= m_valid_next;
            phase_acc_reg    <= phase_acc_next;
            phase_inc_reg    <= phase_inc_next;
            sample_index_reg <= sample_index_next;
            progress_reg     <= progress_next;
            decay_level_reg  <= decay_level_next;
            lfsr_reg         <= lfsr_next;
            sounding_reg     <= sounding_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        mix_reg       <= mix_next;
        tone_reg      <= tone_next;
        active_reg    <= active_next;
        last_reg      <= last_next;
        in_attack_reg <= in_attack_next;
        env_reg       <= env_next;
        fade_reg      <= fade_next;
        gain_reg      <= gain_next;
        decay_new_reg <= decay_new_next;
        m_mix_out_reg <= m_mix_out_next;
        m_tone_reg    <= m_tone_next;
        m_active_reg  <= m_active_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_mix_out     = m_mix_out_reg;
    assign m_tone_sample = m_tone_reg;
    assign m_active      = m_active_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

>>> rtl/steg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module steg_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [steg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [steg_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output steg_pkg::steg_cfg_t              cfg
);
    import steg_pkg::*;

    steg_cfg_t cfg_reg;
    steg_cfg_t cfg_next;

    // Decode the write and take the low bits of the data
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WAVEFORM:      cfg_next.waveform        = cfg_wr_data[2:0];
                CFG_START_INC:     cfg_next.start_increment = cfg_wr_data[30:0];
                CFG_SWEEP_STEP:    cfg_next.sweep_step      = signed'(cfg_wr_data[20:0]);
                CFG_PROGRESS_STEP: cfg_next.progress_step   = cfg_wr_data[24:0];
                CFG_ATTACK_LENGTH: cfg_next.attack_length   = cfg_wr_data[19:0];
                CFG_ATTACK_STEP:   cfg_next.attack_step     = cfg_wr_data[15:0];
                CFG_DECAY_FACTOR:  cfg_next.decay_factor    = cfg_wr_data[15:0];
                CFG_VOLUME:        cfg_next.volume          = cfg_wr_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/steg_digit_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module steg_digit_mul (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  steg_pkg::steg_mul_req_t req,
    output steg_pkg::steg_mul_rsp_t rsp
);
    import steg_pkg::*;

    logic [MUL_AW-1:0]             a_reg;
    logic [MUL_AW-1:0]             a_next;
    logic [MUL_PW-1:0]             acc_reg;
    logic [MUL_PW-1:0]             acc_next;
    logic [MUL_CNT_W-1:0]          cnt_reg;
    logic [MUL_CNT_W-1:0]          cnt_next;
    logic [MUL_DIGIT_W-1:0]        digit;
    logic [MUL_AW+MUL_DIGIT_W-1:0] partial;
    logic [MUL_AW+MUL_DIGIT_W-1:0] sum;

    // Multiply the stored operand by the lowest multiplier digit
    assign digit   = acc_reg[MUL_DIGIT_W-1:0];
    assign partial = (MUL_AW+MUL_DIGIT_W)'(a_reg) * (MUL_AW+MUL_DIGIT_W)'(digit);
    assign sum     = (MUL_AW+MUL_DIGIT_W)'(acc_reg[MUL_PW-1:MUL_BW]) + partial;

    // Load operands, then shift one digit out and the partial sum in each cycle
    always_comb begin
        a_next   = a_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (req.load) begin
            a_next   = req.a;
            acc_next = {{MUL_AW{1'b0}}, req.b};
            cnt_next = MUL_CNT_W'(MUL_DIGITS);
        end else if (cnt_reg != '0) begin
            acc_next = {sum, acc_reg[MUL_BW-1:MUL_DIGIT_W]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign rsp.busy    = (cnt_reg != '0);
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

>>> rtl/steg_osc.sv
`timescale 1ns / 1ps
`default_nettype none

module steg_osc (
    input  logic [2:0]         waveform,
    input  logic [31:0]        phase,
    input  logic [15:0]        lfsr,
    output logic signed [15:0] osc
);
    import steg_pkg::*;

    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]                 quad;
    logic [SINE_QBITS-1:0]      r;
    logic [SINE_QBITS-1:0]      idx;
    logic                       peak;
    logic [14:0]                mag;
    logic [15:0]                sine;
    logic [31:0]                tri_d;
    logic [16:0]                tri_q;
    logic [15:0]                tri_v;
    logic [15:0]                saw;
    logic [15:0]                square;

    // Sine: fold the phase onto the quarter table; the crest is not stored
    assign k    = phase[31 -: SINE_TABLE_BITS];
    assign quad = k[SINE_TABLE_BITS-1 -: 2];
    assign r    = k[SINE_QBITS-1:0];
    assign idx  = quad[0] ? SINE_QBITS'(~r + 1'b1) : r;
    assign peak = quad[0] && (r == '0);
    assign mag  = peak ? 15'h7FFF : SINE_LUT[idx];
    assign sine = quad[1] ? (~{1'b0, mag} + 16'd1) : {1'b0, mag};

    // Triangle: distance from mid-phase, capped at full scale
    assign tri_d = phase[31] ? {1'b0, phase[30:0]} : (32'h8000_0000 - {1'b0, phase[30:0]});
    assign tri_q = tri_d[31:15];
    assign tri_v = tri_q[16] ? 16'h7FFF : {~tri_q[15], tri_q[14:0]};

    assign saw    = {~phase[31], phase[30:16]};
    assign square = phase[31] ? 16'h8000 : 16'h7FFF;

    // Select the waveform
    always_comb begin
        unique case (waveform)
            WAVE_SINE:     osc = signed'(sine);
            WAVE_SQUARE:   osc = signed'(square);
            WAVE_TRIANGLE: osc = signed'(tri_v);
            WAVE_SAW:      osc = signed'(saw);
            WAVE_NOISE:    osc = signed'(lfsr);
            default:       osc = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sim/swept_tone_envelope_generator_tb.sv
`timescale 1ns / 1ps

module swept_tone_envelope_generator_tb;
    import steg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned LONG_HOLD     = 500;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned PRINT_LIMIT   = 40;

    // Voice constants, kept apart from the design's own copies
    localparam int unsigned   QUARTER_BITS   = 8;
    localparam logic [15:0]   NOISE_TAPS     = 16'hB400;
    localparam logic [15:0]   NOISE_SEED     = 16'hACE1;
    localparam logic [63:0]   PROGRESS_ONE   = 64'h100_0000;
    localparam logic [19:0]   NOTE_INDEX_MAX = 20'hF_FFFF;
    localparam longint        STEP_CEILING   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [2:0]    WAVE_UNUSED    = 3'd6;

    typedef struct {
        logic signed [15:0] mix_in;
        logic               restart;
    } sample_req_t;

    typedef struct {
        logic signed [15:0] mix_out;
        logic signed [15:0] tone;
        logic               active;
        logic               last;
    } tone_result_t;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index   = CFG_WAVEFORM;
    logic [CFG_DATA_W-1:0]     cfg_wr_data = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic signed [15:0]        s_mix_in    = '0;
    logic                      s_restart   = 1'b0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic signed [15:0]        m_mix_out;
    logic signed [15:0]        m_tone_sample;
    logic                      m_active;
    logic                      m_last;

    swept_tone_envelope_generator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mix_in      (s_mix_in),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mix_out     (m_mix_out),
        .m_tone_sample (m_tone_sample),
        .m_active      (m_active),
        .m_last        (m_last)
    );

    always #5 aclk = ~aclk;

    // Voice settings as the design should hold them
    logic [2:0]         wave_sel         = WAVE_SINE;
    logic [30:0]        start_inc        = 31'd0;
    logic signed [20:0] sweep            = 21'sd0;
    logic [24:0]        prog_step        = 25'd65536;
    logic [19:0]        attack_len       = 20'd220;
    logic [15:0]        attack_gain_step = 16'd297;
    logic [15:0]        decay_mul        = 16'd65530;
    logic [15:0]        volume_gain      = 16'd32768;

    // Voice state
    logic [31:0] osc_phase     = '0;
    logic [31:0] osc_step      = '0;
    logic [19:0] note_index    = '0;
    logic [24:0] note_progress = '0;
    logic [15:0] decay_level   = 16'hFFFF;
    logic [15:0] noise_reg     = NOISE_SEED;
    logic        note_on       = 1'b0;

    sample_req_t  sample_queue[$];
    tone_result_t tone_expect[$];
    sample_req_t  next_sample;
    tone_result_t due;

    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned tones_ended     = 0;
    int unsigned reg_writes      = 0;
    int unsigned planned_len     = 160;

    int unsigned send_gap    = 0;
    int unsigned take_gap    = 0;
    bit          send_steady = 1'b0;
    bit          take_steady = 1'b1;
    int unsigned hold_req    = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;

    task automatic report_mismatch(string note);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, note);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap(bit steady);
        if (steady)
            return 0;
        if ($urandom_range(0, 99) < 4)
            return $urandom_range(20, 80);
        return $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
    endfunction

    // Quarter-wave polynomial, mirrored and negated for the other quadrants
    function automatic longint sine_value(logic [QUARTER_BITS+1:0] k);
        logic [63:0] pos;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] c1;
        logic [63:0] c2;
        logic [63:0] y;
        logic [63:0] v;
        pos = k[QUARTER_BITS] ? (64'd1 << QUARTER_BITS) - 64'(k[QUARTER_BITS-1:0])
                              : 64'(k[QUARTER_BITS-1:0]);
        x  = pos << (16 - QUARTER_BITS);
        x2 = (x * x) >> 16;
        c1 = 64'd42048 - ((64'd4640 * x2) >> 16);
        c2 = 64'd102944 - ((x2 * c1) >> 16);
        y  = (x * c2) >> 16;
        v  = (y + 64'd1) >> 1;
        if (v > 64'd32767)
            v = 64'd32767;
        return k[QUARTER_BITS+1] ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint wave_value(logic [31:0] ph);
        logic [31:0] d;
        longint      v;
        case (wave_sel)
            WAVE_SINE:     return sine_value(ph[31:32-QUARTER_BITS-2]);
            WAVE_SQUARE:   return ph[31] ? -32768 : 32767;
            WAVE_TRIANGLE: begin
                d = ph[31] ? ph - 32'h8000_0000 : 32'h8000_0000 - ph;
                v = longint'({32'd0, d >> 15}) - 32768;
                return (v > 32767) ? 32767 : v;
            end
            WAVE_SAW:      return longint'(ph[31:16]) - 32768;
            WAVE_NOISE:    return longint'($signed(noise_reg));
            default:       return 0;
        endcase
    endfunction

    // Advance the voice by one sample tick and return the mixed result
    function automatic tone_result_t next_tone_result(logic signed [15:0] mix_in,
                                                      logic restart);
        tone_result_t r;
        logic [63:0]  env;
        logic [63:0]  p;
        logic [63:0]  fade;
        logic [63:0]  gain;
        logic [63:0]  np;
        longint       tone;
        longint       mix;
        longint       step;
        tone     = 0;
        r.active = 1'b0;
        r.last   = 1'b0;
        if (restart) begin
            osc_phase     = '0;
            osc_step      = {1'b0, start_inc};
            note_index    = '0;
            note_progress = '0;
            decay_level   = 16'hFFFF;
            note_on       = 1'b1;
        end
        if (note_on) begin
            osc_phase = osc_phase + osc_step;
            // attack ramp, then multiplicative decay
            if (note_index < attack_len) begin
                env = 64'(note_index) * 64'(attack_gain_step);
                if (env > 64'd65535)
                    env = 64'd65535;
            end else begin
                env         = 64'(decay_level);
                decay_level = 16'((64'(decay_level) * 64'(decay_mul)) >> 16);
            end
            p    = 64'(note_progress) >> 8;
            fade = 64'd65536 - ((p * p) >> 16);
            if (fade > 64'd65535)
                fade = 64'd65535;
            gain = (((env * fade) >> 16) * 64'(volume_gain)) >> 16;
            tone = (wave_value(osc_phase) * longint'(gain)) >>> 16;

            noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ NOISE_TAPS) : (noise_reg >> 1);

            // sweep the increment, clamped to the 32-bit range
            step = longint'({32'd0, osc_step}) + longint'(sweep);
            if (step < 0)
                step = 0;
            if (step > STEP_CEILING)
                step = STEP_CEILING;
            osc_step = step[31:0];
            if (note_index != NOTE_INDEX_MAX)
                note_index++;

            r.active = 1'b1;
            np = 64'(note_progress) + 64'(prog_step);
            if (np >= PROGRESS_ONE) begin
                r.last        = 1'b1;
                note_on       = 1'b0;
                note_progress = 25'(PROGRESS_ONE);
            end else begin
                note_progress = np[24:0];
            end
        end
        mix = longint'(mix_in) + tone;
        if (mix > 32767)
            mix = 32767;
        if (mix < -32768)
            mix = -32768;
        r.mix_out = 16'(mix);
        r.tone    = 16'(tone);
        return r;
    endfunction

    // Write one register and mirror it into the predictor
    task automatic write_reg(cfg_index_t idx, logic [30:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            CFG_WAVEFORM:      wave_sel         = data[2:0];
            CFG_START_INC:     start_inc        = data[30:0];
            CFG_SWEEP_STEP:    sweep            = data[20:0];
            CFG_PROGRESS_STEP: prog_step        = data[24:0];
            CFG_ATTACK_LENGTH: attack_len       = data[19:0];
            CFG_ATTACK_STEP:   attack_gain_step = data[15:0];
            CFG_DECAY_FACTOR:  decay_mul        = data[15:0];
            CFG_VOLUME:        volume_gain      = data[15:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Fill the bits above a register's width with junk the design must drop
    function automatic logic [30:0] with_junk(logic [30:0] value, int unsigned w);
        logic [30:0] keep;
        keep = (31'd1 << w) - 31'd1;
        return (31'($urandom) & ~keep) | (value & keep);
    endfunction

    function automatic logic [30:0] pick_setting(logic [30:0] lo, logic [30:0] hi,
                                                 int unsigned typ_lo, int unsigned typ_hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(typ_hi, typ_lo));
        endcase
    endfunction

    task automatic randomise_settings();
        logic [30:0] v;
        v = ($urandom_range(0, 7) == 0) ? 31'($urandom_range(5, 7))
                                        : 31'($urandom_range(0, 4));
        write_reg(CFG_WAVEFORM, with_junk(v, 3));
        v = pick_setting(31'd0, 31'h7FFF_FFFF, 0, 32'h0800_0000);
        write_reg(CFG_START_INC, with_junk(v, 31));
        v = pick_setting(31'h10_0000, 31'h0F_FFFF, 0, 4000);
        if ($urandom_range(0, 1))
            v = -v;
        write_reg(CFG_SWEEP_STEP, with_junk(v, 21));
        case ($urandom_range(0, 11))
            0:       v = 31'd0;
            1:       v = 31'd1;
            2:       v = 31'h100_0000;
            3:       v = 31'h1FF_FFFF;
            default: v = 31'((32'h100_0000) / $urandom_range(1, 150));
        endcase
        write_reg(CFG_PROGRESS_STEP, with_junk(v, 25));
        write_reg(CFG_ATTACK_LENGTH, with_junk(pick_setting(31'd0, 31'hF_FFFF, 0, 40), 20));
        write_reg(CFG_ATTACK_STEP, with_junk(pick_setting(31'd0, 31'hFFFF, 0, 65535), 16));
        write_reg(CFG_DECAY_FACTOR,
                  with_junk(pick_setting(31'd0, 31'hFFFF, 60000, 65535), 16));
        write_reg(CFG_VOLUME, with_junk(pick_setting(31'd0, 31'hFFFF, 0, 65535), 16));
        // expected tone length, capped at 160 samples
        if (prog_step == 0)
            planned_len = 160;
        else
            planned_len = (32'h100_0000 + 32'(prog_step) - 1) / 32'(prog_step);
        if (planned_len > 160)
            planned_len = 160;
    endtask

    task automatic push_sample(logic signed [15:0] mix, logic restart);
        sample_queue.insert(sample_queue.size(), '{mix_in: mix, restart: restart});
    endtask

    // Mostly whole tones with random mix content, some cut short or restarted early
    task automatic queue_tones(int unsigned n);
        int unsigned        left;
        logic signed [15:0] mix;
        left = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                case ($urandom_range(0, 3))
                    0:       mix = -16'sd32768;
                    1:       mix = 16'sd32767;
                    2:       mix = 16'sd0;
                    default: mix = -16'sd1;
                endcase
            end else begin
                mix = 16'($urandom);
            end
            if (left == 0 || $urandom_range(0, 39) == 0) begin
                push_sample(mix, 1'b1);
                left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, planned_len + 3)
                                                   : planned_len + $urandom_range(0, 3);
            end else begin
                push_sample(mix, 1'b0);
                left--;
            end
        end
    endtask

    // Hold until every request is sent and answered, then let the voice settle
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || tone_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                tone_expect.insert(tone_expect.size(),
                                   next_tone_result(s_mix_in, s_restart));
                requests_sent++;
                if ($urandom_range(0, 63) == 0)
                    send_steady = !send_steady;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    next_sample = sample_queue.pop_front();
                    s_valid     <= 1'b1;
                    s_mix_in    <= next_sample.mix_in;
                    s_restart   <= next_sample.restart;
                    send_gap    <= pick_gap(send_steady);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tone_expect.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, mix_out %0d",
                                              m_mix_out));
                end else begin
                    due = tone_expect.pop_front();
                    if (m_mix_out !== due.mix_out)
                        report_mismatch($sformatf("result %0d mix_out %0d, expected %0d",
                                                  results_checked, m_mix_out, due.mix_out));
                    if (m_tone_sample !== due.tone)
                        report_mismatch($sformatf("result %0d tone_sample %0d, expected %0d",
                                                  results_checked, m_tone_sample, due.tone));
                    if (m_active !== due.active)
                        report_mismatch($sformatf("result %0d active %0b, expected %0b",
                                                  results_checked, m_active, due.active));
                    if (m_last !== due.last)
                        report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                                  results_checked, m_last, due.last));
                    if (due.last)
                        tones_ended++;
                end
                results_checked++;
                if ($urandom_range(0, 63) == 0)
                    take_steady = !take_steady;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen++;
                hold_left = LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (take_gap != 0) begin
                take_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                take_gap = pick_gap(take_steady);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, tone_expect.size());
            $display("swept_tone_envelope_generator test failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // silent pass-through at the mix extremes, then a sine tone on defaults
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd1234, 1'b0);
        push_sample(-16'sd1, 1'b0);
        wait_drained();

        // loud two-sample square tone driving the mix into both rails
        write_reg(CFG_WAVEFORM, 31'(WAVE_SQUARE));
        write_reg(CFG_START_INC, 31'h7FFF_FFFF);
        write_reg(CFG_SWEEP_STEP, 31'd0);
        write_reg(CFG_PROGRESS_STEP, 31'h80_0000);
        write_reg(CFG_ATTACK_LENGTH, 31'd0);
        write_reg(CFG_DECAY_FACTOR, 31'hFFFF);
        write_reg(CFG_VOLUME, 31'hFFFF);
        push_sample(16'sd32767, 1'b1);
        push_sample(-16'sd32768, 1'b0);
        push_sample(-16'sd32768, 1'b0);
        wait_drained();

        // one-sample tones, restarted back to back
        write_reg(CFG_PROGRESS_STEP, 31'h100_0000);
        push_sample(16'sd100, 1'b1);
        push_sample(-16'sd100, 1'b1);
        wait_drained();

        // endless triangle: clipped attack, decay to nothing, increment floored at zero,
        // restart while sounding
        write_reg(CFG_WAVEFORM, 31'(WAVE_TRIANGLE));
        write_reg(CFG_START_INC, 31'd5);
        write_reg(CFG_SWEEP_STEP, 31'h10_0000);
        write_reg(CFG_PROGRESS_STEP, 31'd0);
        write_reg(CFG_ATTACK_LENGTH, 31'd3);
        write_reg(CFG_ATTACK_STEP, 31'hFFFF);
        write_reg(CFG_DECAY_FACTOR, 31'd0);
        push_sample(16'sd0, 1'b1);
        repeat (4) push_sample(16'($urandom), 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd0, 1'b0);
        wait_drained();

        // unused waveform code keeps the tone running but silent
        write_reg(CFG_WAVEFORM, 31'(WAVE_UNUSED));
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd5, 1'b0);
        wait_drained();

        write_reg(CFG_WAVEFORM, 31'(WAVE_NOISE));
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        wait_drained();

        // upward sweep at the largest step from the largest start increment
        write_reg(CFG_WAVEFORM, 31'(WAVE_SAW));
        write_reg(CFG_START_INC, 31'h7FFF_FFFF);
        write_reg(CFG_SWEEP_STEP, 31'h0F_FFFF);
        write_reg(CFG_ATTACK_LENGTH, 31'd0);
        write_reg(CFG_DECAY_FACTOR, 31'hFFFF);
        push_sample(16'($urandom), 1'b1);
        repeat (120) push_sample(16'($urandom), 1'b0);
        wait_drained();

        // random settings, each phase a run of tones
        for (int phase = 0; phase < 12; phase++) begin
            randomise_settings();
            queue_tones(120);
            if (phase == 3)
                hold_req <= hold_req + 1;
            wait_drained();
        end

        $display("covered %0d requests over %0d register writes, all waveforms and sweeps",
                 requests_sent, reg_writes);
        $display("checked %0d results, %0d tones ran to their end, %0d mismatches",
                 results_checked, tones_ended, mismatch_count);
        if (mismatch_count == 0)
            $display("swept_tone_envelope_generator test passed");
        else
            $display("swept_tone_envelope_generator test failed");
        $finish;
    end

endmodule
